[design/square_and_perfect_classifier_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for square_and_perfect_classifier
// Shorthand for clocked, reset-gated concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SQUARE_AND_PERFECT_CLASSIFIER_ASSERT_SVH
`define SQUARE_AND_PERFECT_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define SAPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sapc_pkg.sv]
// ----------------------------------------------------------------------------
// sapc_pkg
// Shared types and constants of the square and perfect number classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sapc_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int TALLY_BITS     = 16;
    localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_ADD,
        ST_FIN
    } sapc_state_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_stat_t;

endpackage

[design/square_and_perfect_classifier.sv]
// ----------------------------------------------------------------------------
// square_and_perfect_classifier
// Flags each signed value as perfect square and/or perfect number, with
// per-list running counts.
// ----------------------------------------------------------------------------
// A value v > 0 walks candidate divisors d = 1, 2, ... while d*d <= v; each
// candidate costs one pass through the shared bit-serial divider (states
// TEST and DIV) plus an ADD step that adds the cofactor; the FIN state then
// hands the result to the output register. Zero and negative values skip the
// divisor search and go straight to FIN. The input is ready only while the
// sequencer is idle; a finished result waits in the output register and the
// next value is taken meanwhile.
`timescale 1ns / 1ps

`include "square_and_perfect_classifier_assert.svh"

module square_and_perfect_classifier
    import sapc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0]      s_tdata,  // value
    input  logic                                         s_tlast,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // echo_value, square_total, perfect_total
    output logic [((VALUE_BITS + 2 * TALLY_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [1:0]                                   m_tuser,  // is_square, is_perfect
    output logic                                         m_tlast
);

    localparam int W   = VALUE_BITS;
    localparam int DW  = VALUE_BITS / 2 + 1;
    localparam int SW  = VALUE_BITS + 4;
    localparam int OW  = ((VALUE_BITS + 2 * TALLY_BITS + 7) / 8) * 8;

    sapc_state_t            state_reg, state_next;
    logic [W-1:0]           raw_reg, raw_next;
    logic                   last_reg, last_next;
    logic                   pos_reg, pos_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [W:0]             dsq_reg, dsq_next;
    logic [SW-1:0]          sum_reg, sum_next;
    logic                   sq_reg, sq_next;
    logic                   rz_reg, rz_next;
    logic [W-1:0]           q_reg, q_next;
    logic [TALLY_BITS-1:0]  sq_tally_reg, sq_tally_next;
    logic [TALLY_BITS-1:0]  pf_tally_reg, pf_tally_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [W-1:0]           echo_out_reg, echo_out_next;
    logic                   sqf_out_reg, sqf_out_next;
    logic                   pff_out_reg, pff_out_next;
    logic [TALLY_BITS-1:0]  sqt_out_reg, sqt_out_next;
    logic [TALLY_BITS-1:0]  pft_out_reg, pft_out_next;
    logic                   last_out_reg, last_out_next;

    logic                   div_start;
    logic [W-1:0]           div_quot;
    div_stat_t              div_stat;
    logic                   load;
    logic                   pf_flag;
    logic [TALLY_BITS-1:0]  sq_inc;
    logic [TALLY_BITS-1:0]  pf_inc;

    sapc_div #(
        .DIVIDEND_BITS (W),
        .DIVISOR_BITS  (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (raw_reg),
        .divisor  (d_reg),
        .quot     (div_quot),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sq_tally_reg <= '0;
            pf_tally_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sq_tally_reg <= sq_tally_next;
            pf_tally_reg <= pf_tally_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg      <= raw_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        d_reg        <= d_next;
        dsq_reg      <= dsq_next;
        sum_reg      <= sum_next;
        sq_reg       <= sq_next;
        rz_reg       <= rz_next;
        q_reg        <= q_next;
        echo_out_reg <= echo_out_next;
        sqf_out_reg  <= sqf_out_next;
        pff_out_reg  <= pff_out_next;
        sqt_out_reg  <= sqt_out_next;
        pft_out_reg  <= pft_out_next;
        last_out_reg <= last_out_next;
    end

    assign pf_flag = pos_reg && (sum_reg == SW'({raw_reg, 1'b0}));
    assign sq_inc  = (sq_reg && sq_tally_reg != TALLY_MAX) ? sq_tally_reg + TALLY_BITS'(1)
                                                            : sq_tally_reg;
    assign pf_inc  = (pf_flag && pf_tally_reg != TALLY_MAX) ? pf_tally_reg + TALLY_BITS'(1)
                                                             : pf_tally_reg;

    always_comb
    begin
        state_next    = state_reg;
        raw_next      = raw_reg;
        last_next     = last_reg;
        pos_next      = pos_reg;
        d_next        = d_reg;
        dsq_next      = dsq_reg;
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        rz_next       = rz_reg;
        q_next        = q_reg;
        sq_tally_next = sq_tally_reg;
        pf_tally_next = pf_tally_reg;
        echo_out_next = echo_out_reg;
        sqf_out_next  = sqf_out_reg;
        pff_out_next  = pff_out_reg;
        sqt_out_next  = sqt_out_reg;
        pft_out_next  = pft_out_reg;
        last_out_next = last_out_reg;
        div_start     = 1'b0;
        load          = 1'b0;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    raw_next  = s_tdata[W-1:0];
                    last_next = s_tlast;
                    pos_next  = !s_tdata[W-1] && (s_tdata[W-1:0] != '0);
                    sq_next   = (s_tdata[W-1:0] == '0);
                    d_next    = DW'(1);
                    dsq_next  = (W+1)'(1);
                    sum_next  = '0;
                    state_next = (!s_tdata[W-1] && (s_tdata[W-1:0] != '0)) ? ST_TEST
                                                                            : ST_FIN;
                end
            end
            ST_TEST:
            begin
                if (dsq_reg <= {1'b0, raw_reg})
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    rz_next = div_stat.rem_zero;
                    q_next  = div_quot;
                    if (div_stat.rem_zero)
                    begin
                        sum_next = sum_reg + SW'(d_reg);
                    end
                    if (dsq_reg == {1'b0, raw_reg})
                    begin
                        sq_next = 1'b1;
                    end
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (rz_reg && (q_reg != W'(d_reg)))
                begin
                    sum_next = sum_reg + SW'(q_reg);
                end
                dsq_next   = dsq_reg + (W+1)'({d_reg, 1'b1});
                d_next     = d_reg + DW'(1);
                state_next = ST_TEST;
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load          = 1'b1;
                    echo_out_next = raw_reg;
                    sqf_out_next  = sq_reg;
                    pff_out_next  = pf_flag;
                    sqt_out_next  = sq_inc;
                    pft_out_next  = pf_inc;
                    last_out_next = last_reg;
                    sq_tally_next = last_reg ? '0 : sq_inc;
                    pf_tally_next = last_reg ? '0 : pf_inc;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OW'({pft_out_reg, sqt_out_reg, echo_out_reg});
    assign m_tuser  = {pff_out_reg, sqf_out_reg};
    assign m_tlast  = last_out_reg;

    `SAPC_ASSERT_IMP(a_neg_no_flags, m_tvalid && echo_out_reg[W-1], m_tuser == 2'b00,
                     "negative value flagged")
    `SAPC_ASSERT_IMP(a_square_counted, m_tvalid && sqf_out_reg, sqt_out_reg != '0,
                     "square not counted")
    `SAPC_ASSERT_NXT(a_tally_clear, load && last_reg,
                     sq_tally_reg == '0 && pf_tally_reg == '0,
                     "tally not cleared at list end")

endmodule

[design/sapc_div.sv]
// ----------------------------------------------------------------------------
// sapc_div
// Restoring divider, one quotient bit per cycle, shared by the divisor search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sapc_div
    import sapc_pkg::*;
#(
    parameter int DIVIDEND_BITS = VALUE_BITS_DEF,
    parameter int DIVISOR_BITS  = VALUE_BITS_DEF / 2 + 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic [DIVIDEND_BITS-1:0] quot,
    output div_stat_t                stat
);

    localparam int CW = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg, busy_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIVIDEND_BITS);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CW'(1);
                rem_next = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], ge};
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign quot          = quo_reg;
    assign stat.done     = busy_reg && (cnt_reg == '0);
    assign stat.rem_zero = (rem_reg == '0);

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for square_and_perfect_classifier. Signed values are sent
// in lists closed by tlast. Each result beat is checked against a behavioral
// predictor: the echoed value, the perfect-square flag, the perfect-number
// flag, the saturating per-list counts and tlast. The test covers directed
// edge values, a long receiver hold-off, a back-to-back run of squares and
// random lists, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import sapc_pkg::*;
;

    localparam int VBITS       = VALUE_BITS_DEF;
    localparam int DATA_IN_W   = ((VBITS + 7) / 8) * 8;
    localparam int DATA_OUT_W  = ((VBITS + 2 * TALLY_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int PRINT_LIMIT = 30;

    typedef struct packed {
        logic [VBITS-1:0]      value;
        logic                  square;
        logic                  perfect;
        logic [TALLY_BITS-1:0] square_total;
        logic [TALLY_BITS-1:0] perfect_total;
        logic                  eol;
    } class_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata = '0;   // value
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;        // echo_value, square_total, perfect_total
    logic [1:0]            m_tuser;        // is_square, is_perfect
    logic                  m_tlast;

    class_result_t         classified_q[$];
    logic [TALLY_BITS-1:0] square_count = '0;
    logic [TALLY_BITS-1:0] perfect_count = '0;
    logic                  idle_en = 1'b1;
    logic                  hold_off = 1'b0;
    int                    stall_left = 0;
    int                    error_count = 0;
    int                    cycle_count = 0;

    square_and_perfect_classifier #(.VALUE_BITS(VBITS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Classify the value and advance the per-list counts.
    task automatic predict_classification(input logic [VBITS-1:0] raw, input logic last);
        class_result_t res;
        int n;
        int root;
        int d;
        int div_sum;
        begin
            n = int'($signed(raw));
            res.value = raw;
            res.square = 1'b0;
            res.perfect = 1'b0;
            if (n >= 0)
            begin
                root = 0;
                while ((root + 1) * (root + 1) <= n)
                    root++;
                res.square = (root * root == n);
            end
            if (n > 0)
            begin
                div_sum = 0;
                for (d = 1; d * d <= n; d++)
                begin
                    if (n % d == 0)
                    begin
                        div_sum += d;
                        if (n / d != d)
                            div_sum += n / d;
                    end
                end
                res.perfect = (div_sum == 2 * n);
            end
            if (res.square && square_count != TALLY_MAX)
                square_count = square_count + TALLY_BITS'(1);
            if (res.perfect && perfect_count != TALLY_MAX)
                perfect_count = perfect_count + TALLY_BITS'(1);
            res.square_total = square_count;
            res.perfect_total = perfect_count;
            res.eol = last;
            classified_q.push_back(res);
            if (last)
            begin
                square_count = '0;
                perfect_count = '0;
            end
        end
    endtask

    task automatic send_beat(input logic [VBITS-1:0] value, input logic last);
        int gap;
        begin
            gap = idle_en ? pick_gap() : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= value;
            s_tlast <= last;
            do @(posedge clk); while (!s_tready);
            predict_classification(value, last);
        end
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        begin
            if (error_count < PRINT_LIMIT)
                $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
            error_count++;
        end
    endtask

    // Receiver: random stalls, plus a forced hold-off while hold_off is high.
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_en)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        class_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (classified_q.size() == 0)
                report_mismatch("unexpected beat", longint'(m_tdata[VBITS-1:0]), longint'(0));
            else
            begin
                want = classified_q.pop_front();
                if (m_tdata[VBITS-1:0] !== want.value)
                    report_mismatch("echo_value", longint'($signed(m_tdata[VBITS-1:0])),
                                    longint'($signed(want.value)));
                if (m_tuser[0] !== want.square)
                    report_mismatch("is_square", longint'(m_tuser[0]), longint'(want.square));
                if (m_tuser[1] !== want.perfect)
                    report_mismatch("is_perfect", longint'(m_tuser[1]), longint'(want.perfect));
                if (m_tdata[VBITS+TALLY_BITS-1:VBITS] !== want.square_total)
                    report_mismatch("square_total",
                                    longint'(m_tdata[VBITS+TALLY_BITS-1:VBITS]),
                                    longint'(want.square_total));
                if (m_tdata[VBITS+2*TALLY_BITS-1:VBITS+TALLY_BITS] !== want.perfect_total)
                    report_mismatch("perfect_total",
                                    longint'(m_tdata[VBITS+2*TALLY_BITS-1:VBITS+TALLY_BITS]),
                                    longint'(want.perfect_total));
                if (m_tlast !== want.eol)
                    report_mismatch("end_of_list", longint'(m_tlast), longint'(want.eol));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic apply_reset();
        begin
            rst_n <= 1'b0;
            repeat (11) @(posedge clk);
            rst_n <= 1'b1;
            @(posedge clk);
        end
    endtask

    task automatic test_edge_values();
        logic [VBITS-1:0] values[22];
        logic             lasts[22];
        int i;
        begin
            values = '{16'sd0, 16'sd1, -16'sd1, 16'h8000, 16'sd32767, 16'sd32761,
                       16'sd32760, 16'sd4, 16'sd2, 16'sd6, 16'sd28, 16'sd496,
                       16'sd8128, 16'sd8127, 16'sd16384, 16'sd15, -16'sd4, -16'sd6,
                       16'h5555, 16'hAAAA, 16'sd24, 16'sd12};
            lasts = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                      1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
            for (i = 0; i < 22; i++)
                send_beat(values[i], lasts[i]);
        end
    endtask

    task automatic test_output_backpressure();
        logic [VBITS-1:0] values[8];
        int i;
        begin
            values = '{16'sd0, 16'sd1, 16'sd4, 16'sd6, -16'sd3, 16'sd9, 16'sd0, 16'sd28};
            fork
                begin
                    hold_off <= 1'b1;
                    repeat (400) @(posedge clk);
                    hold_off <= 1'b0;
                end
                begin
                    for (i = 0; i < 8; i++)
                        send_beat(values[i], i == 7);
                end
            join
        end
    endtask

    // Send a run of squares back to back within one list.
    task automatic test_square_run();
        int i;
        begin
            idle_en = 1'b0;
            for (i = 0; i < 19; i++)
                send_beat('0, 1'b0);
            send_beat(16'sd4, 1'b1);
            idle_en = 1'b1;
        end
    endtask

    task automatic test_random_lists();
        int i;
        int roll;
        int root;
        int perfects[4];
        logic [VBITS-1:0] v;
        begin
            perfects = '{6, 28, 496, 8128};
            for (i = 0; i < 170; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 25)
                    v = VBITS'($urandom);
                else if (roll < 50)
                begin
                    root = $urandom_range(0, 181);
                    v = VBITS'(root * root);
                end
                else if (roll < 65)
                    v = VBITS'(perfects[$urandom_range(0, 3)]);
                else if (roll < 80)
                    v = VBITS'(-$urandom_range(1, 32768));
                else
                    v = VBITS'($urandom_range(0, 100));
                send_beat(v, ($urandom_range(0, 7) == 0) || (i == 169));
            end
        end
    endtask

    initial
    begin
        apply_reset();
        test_edge_values();
        test_output_backpressure();
        test_square_run();
        test_random_lists();
        s_tvalid <= 1'b0;
        while (classified_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/sapc_pkg.sv
design/sapc_div.sv
design/square_and_perfect_classifier.sv
test/tb_top.sv
